@@ sv/morph_target_blend_accumulate_unit_defines.svh @@
// assertion macros for the morph target blend accumulate unit
// included by files that carry concurrent assertions, no other dependencies
`ifndef MORPH_TARGET_BLEND_ACCUMULATE_UNIT_DEFINES_SVH
`define MORPH_TARGET_BLEND_ACCUMULATE_UNIT_DEFINES_SVH

// same-cycle implication under asynchronous active-low reset
`define MTBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define MTBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mtba_pkg.sv @@
// shared types and constants of the morph target blend accumulate unit
// no dependencies
`default_nettype none

package mtba_pkg;

	// op codes on the input stream
	localparam logic [2:0] OP_LOAD  = 3'd0;
	localparam logic [2:0] OP_CHAN  = 3'd1;
	localparam logic [2:0] OP_THR   = 3'd2;
	localparam logic [2:0] OP_DELTA = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// register word address on the config port
	localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;

	// factor format: unsigned q1.16, one = 65536
	localparam int FW = 17;
	localparam logic [FW-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic [2:0] {
		K_LOAD,
		K_CHAN,
		K_THR,
		K_DELTA,
		K_READ
	} mtba_kind_t;

	// one classified item as it sits in the queue
	typedef struct packed {
		mtba_kind_t         kind;
		logic [11:0]        vertex_index;
		logic [2:0]         shape_slot;
		logic signed [23:0] value;
		logic               last;
		logic [5:0][31:0]   data;   // px py pz nx ny nz, px lowest
	} mtba_item_t;

	typedef enum logic {
		DS_DIV,
		DS_SQRT
	} mtba_ds_mode_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_EXEC,
		B_DLOAD,
		B_DMUL,
		B_DADD,
		B_DSTORE,
		B_RLOAD,
		B_SQMUL,
		B_SQADD,
		B_SQCHK,
		B_SQRT,
		B_NDIV_ST,
		B_NDIV,
		B_OUT,
		B_FINIT,
		B_FLAST,
		B_FSCAN,
		B_FDIV
	} mtba_state_t;

endpackage

`default_nettype wire

@@ sv/mtba_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mtba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WIDTH-1:0]     rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/mtba_fifo.sv @@
// small first-in first-out queue between the front and back parts
// no dependencies
`default_nettype none

module mtba_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] dout,
	output logic                  full,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= din;
		end
	end

endmodule

`default_nettype wire

@@ sv/mtba_divsqrt.sv @@
// shared iterative unit: restoring divide (48/32) or integer square root (64 bits)
// one result bit per cycle; uses mtba_pkg
`default_nettype none

module mtba_divsqrt import mtba_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  mtba_ds_mode_t      mode,
	input  wire logic [63:0]   opa,    // div: numerator in [47:0]; sqrt: radicand
	input  wire logic [31:0]   opb,    // div: divisor
	output logic               done,
	output logic [47:0]        res     // div: quotient; sqrt: root in [31:0]
);
	mtba_ds_mode_t mode_q;
	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [35:0]   rem_q;
	logic [63:0]   src_q;
	logic [47:0]   res_q;
	logic [31:0]   den_q;

	logic [35:0]   rs_div;
	logic [35:0]   rs_sq;
	logic [35:0]   trial;
	logic          ge;
	logic [35:0]   rem_d;
	logic [63:0]   src_d;

	assign done = done_q;
	assign res  = res_q;

	always_comb begin
		rs_div = {rem_q[34:0], src_q[63]};
		rs_sq  = {rem_q[33:0], src_q[63:62]};
		trial  = {2'b00, res_q[31:0], 2'b01};
		if (mode_q == DS_SQRT) begin
			ge    = (rs_sq >= trial);
			rem_d = ge ? rs_sq - trial : rs_sq;
			src_d = {src_q[61:0], 2'b00};
		end else begin
			ge    = (rs_div >= {4'b0000, den_q});
			rem_d = ge ? rs_div - {4'b0000, den_q} : rs_div;
			src_d = {src_q[62:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= (mode == DS_SQRT) ? 6'd32 : 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode;
			rem_q  <= '0;
			res_q  <= '0;
			den_q  <= opb;
			src_q  <= (mode == DS_SQRT) ? opa : {opa[47:0], 16'h0000};
		end else if (busy_q) begin
			rem_q <= rem_d;
			src_q <= src_d;
			res_q <= {res_q[46:0], ge};
		end
	end

endmodule

`default_nettype wire

@@ sv/mtba_front.sv @@
// front part: stream handshake, op decode and unpacking into queue items
// uses mtba_pkg
`default_nettype none

module mtba_front import mtba_pkg::*; (
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [231:0]  s_tdata,
	input  wire logic [2:0]    s_tuser,
	input  wire logic          s_tlast,
	input  wire logic          q_full,
	output logic               q_push,
	output mtba_item_t         q_item
);
	logic known;

	assign s_tready = !q_full;

	always_comb begin
		known       = 1'b1;
		q_item.kind = K_LOAD;
		case (s_tuser)
			OP_LOAD:  q_item.kind = K_LOAD;
			OP_CHAN:  q_item.kind = K_CHAN;
			OP_THR:   q_item.kind = K_THR;
			OP_DELTA: q_item.kind = K_DELTA;
			OP_READ:  q_item.kind = K_READ;
			default:  known = 1'b0;
		endcase
		q_item.vertex_index = s_tdata[11:0];
		q_item.shape_slot   = s_tdata[14:12];
		q_item.value        = s_tdata[38:15];
		q_item.last         = s_tlast;
		q_item.data         = s_tdata[230:39];
	end

	// undefined ops are taken and dropped here
	assign q_push = s_tvalid && s_tready && known;

endmodule

`default_nettype wire

@@ sv/mtba_back.sv @@
// back part: sequencer for vertex store, factor table, delta accumulate and read
// uses mtba_pkg, mtba_ram, mtba_divsqrt
`default_nettype none

module mtba_back import mtba_pkg::*; #(
	parameter int MAX_VERTICES = 4096,
	parameter int MAX_SHAPES   = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [12:0]   vertex_count,
	input  wire logic          item_valid,
	input  mtba_item_t         item,
	output logic               item_pop,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [191:0]       m_tdata,
	output logic               m_tuser
);
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int SW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
	localparam int CW = $clog2(MAX_SHAPES + 1);

	mtba_state_t        state_q, state_d;
	mtba_item_t         cur_q;
	logic [5:0][31:0]   vec_q;
	logic [2:0]         j_q;
	logic signed [65:0] prod_q;
	logic [63:0]        sq_q;
	logic [31:0]        len_q;
	logic               rng_q;
	logic signed [23:0] weight_q;
	logic [CW-1:0]      cnt_q;
	logic signed [23:0] thr_q [MAX_SHAPES];
	logic [FW-1:0]      fac_q [MAX_SHAPES];
	logic [SW-1:0]      idx_q;
	logic signed [23:0] prev_q;
	logic               fpair_q;
	logic               out_valid_q;
	logic [191:0]       out_data_q;
	logic               out_user_q;

	// ram and divider hookup
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_addr;
	logic [191:0]       ram_wdata, ram_rdata;
	logic               ds_start, ds_done;
	mtba_ds_mode_t      ds_mode;
	logic [63:0]        ds_opa;
	logic [31:0]        ds_opb;
	logic [47:0]        ds_res;

	// factor table writes
	logic               fac_clr;
	logic               fw_en, fw2_en;
	logic [SW-1:0]      fw_idx, fw2_idx;
	logic [FW-1:0]      fw_val, fw2_val;

	logic               slot_ok, ld_ok, dl_ok, rd_ok;
	logic [FW-1:0]      fac_slot;
	logic signed [23:0] t0, t_idx;
	logic signed [24:0] rng, wdiff;
	logic signed [32:0] mul_a, mul_b;
	logic signed [32:0] dsc;
	logic signed [33:0] acc_sum;
	logic [31:0]        acc_sat;
	logic [31:0]        nsel, nmag, nres;
	logic [2:0]         nj;

	mtba_ram #(.WIDTH(192), .DEPTH(MAX_VERTICES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	mtba_divsqrt u_ds (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ds_start),
		.mode   (ds_mode),
		.opa    (ds_opa),
		.opb    (ds_opb),
		.done   (ds_done),
		.res    (ds_res)
	);

	assign ram_addr = AW'(cur_q.vertex_index);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	always_comb begin
		slot_ok  = 32'(cur_q.shape_slot) < 32'(MAX_SHAPES);
		fac_slot = slot_ok ? fac_q[SW'(cur_q.shape_slot)] : '0;
		ld_ok    = 32'(cur_q.vertex_index) < 32'(MAX_VERTICES);
		rd_ok    = ld_ok && ({1'b0, cur_q.vertex_index} < vertex_count);
		dl_ok    = rd_ok && slot_ok && (fac_slot > FW'(1));
		t0       = thr_q[0];
		t_idx    = thr_q[idx_q];
		rng      = 25'(t_idx) - 25'(prev_q);
		wdiff    = 25'(weight_q) - 25'(prev_q);
		nj       = 3'(j_q + 3'd3);
		nsel     = vec_q[nj];
		nmag     = nsel[31] ? 32'(-nsel) : nsel;
	end

	// shared multiplier: delta times factor, or normal component squared
	always_comb begin
		if (state_q == B_DMUL) begin
			mul_a = {cur_q.data[j_q][31], cur_q.data[j_q]};
			mul_b = {16'h0000, fac_slot};
		end else begin
			mul_a = {nsel[31], nsel};
			mul_b = {nsel[31], nsel};
		end
	end

	// floor the scaled delta to q16.16 and add with saturation
	always_comb begin
		dsc     = prod_q[48:16];
		acc_sum = {{2{vec_q[j_q][31]}}, vec_q[j_q]} + {dsc[32], dsc};
		if (acc_sum > 34'sh0_7FFF_FFFF) begin
			acc_sat = 32'h7FFF_FFFF;
		end else if (acc_sum < -34'sh0_8000_0000) begin
			acc_sat = 32'h8000_0000;
		end else begin
			acc_sat = acc_sum[31:0];
		end
	end

	// normal component: quotient with sign restored, saturated
	always_comb begin
		if (!nsel[31]) begin
			nres = (ds_res > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : ds_res[31:0];
		end else begin
			nres = (ds_res > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-ds_res[31:0]);
		end
	end

	always_comb begin
		state_d   = state_q;
		item_pop  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_wdata = vec_q;
		ds_start  = 1'b0;
		ds_mode   = DS_DIV;
		ds_opa    = '0;
		ds_opb    = '0;
		fac_clr   = 1'b0;
		fw_en     = 1'b0;
		fw_idx    = '0;
		fw_val    = ONE_Q16;
		fw2_en    = 1'b0;
		fw2_idx   = '0;
		fw2_val   = '0;
		case (state_q)
			B_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					state_d  = B_EXEC;
				end
			end
			B_EXEC: begin
				state_d = B_IDLE;
				case (cur_q.kind)
					K_LOAD: begin
						ram_we    = ld_ok;
						ram_wdata = cur_q.data;
					end
					K_CHAN: fac_clr = 1'b1;
					K_THR: begin
						if (cur_q.last) begin
							state_d = B_FINIT;
						end
					end
					K_DELTA: begin
						if (dl_ok) begin
							ram_re  = 1'b1;
							state_d = B_DLOAD;
						end
					end
					K_READ: begin
						ram_re  = rd_ok;
						state_d = rd_ok ? B_RLOAD : B_OUT;
					end
					default: state_d = B_IDLE;
				endcase
			end
			B_DLOAD:  state_d = B_DMUL;
			B_DMUL:   state_d = B_DADD;
			B_DADD:   state_d = (j_q == 3'd5) ? B_DSTORE : B_DMUL;
			B_DSTORE: begin
				ram_we  = 1'b1;
				state_d = B_IDLE;
			end
			B_RLOAD:  state_d = B_SQMUL;
			B_SQMUL:  state_d = B_SQADD;
			B_SQADD:  state_d = (j_q == 3'd2) ? B_SQCHK : B_SQMUL;
			B_SQCHK: begin
				if (sq_q > 64'd65536) begin
					ds_start = 1'b1;
					ds_mode  = DS_SQRT;
					ds_opa   = sq_q;
					state_d  = B_SQRT;
				end else begin
					state_d = B_OUT;
				end
			end
			B_SQRT: begin
				if (ds_done) begin
					state_d = B_NDIV_ST;
				end
			end
			B_NDIV_ST: begin
				ds_start = 1'b1;
				ds_opa   = {16'h0000, nmag, 16'h0000};
				ds_opb   = len_q;
				state_d  = B_NDIV;
			end
			B_NDIV: begin
				if (ds_done) begin
					state_d = (j_q == 3'd2) ? B_OUT : B_NDIV_ST;
				end
			end
			B_OUT: begin
				if (!out_valid_q || m_tready) begin
					state_d = B_IDLE;
				end
			end
			B_FINIT: begin
				fac_clr = 1'b1;
				state_d = B_IDLE;
				if (cnt_q == '0) begin
					state_d = B_IDLE;
				end else if (cnt_q == CW'(1) || weight_q <= t0) begin
					if (t0 > 24'sd1) begin
						if (weight_q <= 24'sd0) begin
							state_d = B_IDLE;
						end else if (weight_q >= t0) begin
							fw_en = 1'b1;
						end else begin
							ds_start = 1'b1;
							ds_opa   = {24'h000000, weight_q, 16'h0000};
							ds_opb   = {8'h00, t0};
							state_d  = B_FDIV;
						end
					end else begin
						fw_en  = 1'b1;
						fw_val = (cnt_q == CW'(1) && weight_q <= 24'sd0) ? '0 : ONE_Q16;
					end
				end else begin
					state_d = B_FLAST;
				end
			end
			B_FLAST: begin
				if (weight_q >= t_idx) begin
					fw_en   = 1'b1;
					fw_idx  = idx_q;
					state_d = B_IDLE;
				end else begin
					state_d = B_FSCAN;
				end
			end
			B_FSCAN: begin
				if (weight_q < t_idx) begin
					if (rng > 25'sd1) begin
						ds_start = 1'b1;
						ds_opa   = {23'h000000, wdiff, 16'h0000};
						ds_opb   = {7'h00, rng};
						state_d  = B_FDIV;
					end else begin
						fw_en   = 1'b1;
						fw_idx  = idx_q;
						state_d = B_IDLE;
					end
				end
			end
			B_FDIV: begin
				if (ds_done) begin
					fw_en   = 1'b1;
					fw_val  = ds_res[FW-1:0];
					fw_idx  = fpair_q ? idx_q : '0;
					fw2_en  = fpair_q;
					fw2_idx = SW'(idx_q - 1'b1);
					fw2_val = ONE_Q16 - ds_res[FW-1:0];
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			weight_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_SHAPES; i++) begin
				fac_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == B_EXEC && cur_q.kind == K_CHAN) begin
				weight_q <= cur_q.value;
				cnt_q    <= '0;
			end
			if (state_q == B_EXEC && cur_q.kind == K_THR
				&& 32'(cnt_q) < 32'(MAX_SHAPES)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (fac_clr) begin
				for (int i = 0; i < MAX_SHAPES; i++) begin
					fac_q[i] <= '0;
				end
			end
			if (fw_en) begin
				fac_q[fw_idx] <= fw_val;
			end
			if (fw2_en) begin
				fac_q[fw2_idx] <= fw2_val;
			end
			if (state_q == B_OUT && state_d == B_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (item_pop) begin
			cur_q <= item;
		end
		case (state_q)
			B_EXEC: begin
				rng_q <= rd_ok;
				if (cur_q.kind == K_THR && 32'(cnt_q) < 32'(MAX_SHAPES)) begin
					thr_q[SW'(cnt_q)] <= cur_q.value;
				end
			end
			B_DLOAD, B_RLOAD: begin
				vec_q <= ram_rdata;
				j_q   <= '0;
				sq_q  <= '0;
			end
			B_DADD: begin
				vec_q[j_q] <= acc_sat;
				j_q        <= j_q + 1'b1;
			end
			B_SQADD: begin
				sq_q <= sq_q + prod_q[63:0];
				j_q  <= j_q + 1'b1;
			end
			B_SQRT: begin
				len_q <= ds_res[31:0];
				j_q   <= '0;
			end
			B_NDIV: begin
				if (ds_done) begin
					vec_q[nj] <= nres;
					j_q       <= j_q + 1'b1;
				end
			end
			B_OUT: begin
				if (state_d == B_IDLE) begin
					out_data_q <= rng_q ? vec_q : '0;
					out_user_q <= rng_q;
				end
			end
			B_FINIT: begin
				idx_q   <= SW'(cnt_q - 1'b1);
				fpair_q <= 1'b0;
			end
			B_FLAST: begin
				idx_q  <= SW'(1);
				prev_q <= t0;
			end
			B_FSCAN: begin
				fpair_q <= 1'b1;
				if (!(weight_q < t_idx)) begin
					prev_q <= t_idx;
					idx_q  <= idx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/morph_target_blend_accumulate_unit.sv @@
// top level of the morph target blend accumulate unit: config port, front, queue, back
// uses mtba_pkg, mtba_front, mtba_fifo, mtba_back and the assertion macro header
`default_nettype none
`include "morph_target_blend_accumulate_unit_defines.svh"

// Blends morph targets into a working copy of up to MAX_VERTICES vertices.
// The host streams items on the slave side, op in s_tuser: load vertex writes
// a base position and normal; channel begin sets the weight and clears the
// shape factors; shape threshold appends a threshold and, with s_tlast set,
// computes one q1.16 factor per shape (in-between shapes interpolate the two
// bracketing thresholds); delta scales a position/normal delta by its shape
// factor and adds it with 32-bit saturation; read vertex returns the blended
// position and the normal, scaled to unit length unless it is very short, on
// the master side, with m_tuser set when the index was below vertex_count.
// Undefined ops are taken and dropped. The front decodes items into a
// two-entry queue, so up to two items are taken ahead while the back works and
// while a result waits on m_tready. The back handles one item at a time: a
// threshold with last scans the stored thresholds and may run one division;
// a delta reads the row, runs six multiply-add steps sharing one multiplier
// and writes the row back; a read loads the row and, when the normal is
// normalized, runs a 32-step square root and three 48-step divisions, all on
// one shared iterative unit. The vertex store is one ram of 192-bit rows;
// entries read before they were written return unspecified data.
module morph_target_blend_accumulate_unit import mtba_pkg::*; #(
	parameter int MAX_VERTICES = 4096,
	parameter int MAX_SHAPES   = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// config port, register vertex_count at byte address 0
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [1:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	// input items
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [231:0]  s_tdata,  // vertex_index, shape_slot, value, px, py, pz, nx, ny, nz, pad
	input  wire logic [2:0]    s_tuser,  // op
	input  wire logic          s_tlast,  // last threshold of a channel
	// results
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic      [191:0]  m_tdata,  // out_px, out_py, out_pz, out_nx, out_ny, out_nz
	output logic               m_tuser   // in_range
);
	localparam int IW = $bits(mtba_item_t);

	logic [12:0]  vertex_count_q;
	logic         cfg_we;
	logic         q_push, q_pop, q_full, q_empty;
	mtba_item_t   q_item;
	logic [IW-1:0] q_dout;

	// config register: single word, written on the access cycle
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr == REG_VERTEX_COUNT) ? {19'h00000, vertex_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_we) begin
			vertex_count_q <= pwdata[12:0];
		end
	end

	// front: decode and unpack
	mtba_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	// queue between the two parts
	mtba_fifo #(.WIDTH(IW), .DEPTH(2)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_item),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: vertex store, factors, arithmetic and result register
	mtba_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_SHAPES(MAX_SHAPES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_count (vertex_count_q),
		.item_valid   (!q_empty),
		.item         (mtba_item_t'(q_dout)),
		.item_pop     (q_pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

	`MTBA_ASSERT_IMP(a_push_not_full, clk, arst_n, q_push, !q_full, "push into full queue")
	`MTBA_ASSERT_IMP(a_pop_not_empty, clk, arst_n, q_pop, !q_empty, "pop from empty queue")
	`MTBA_ASSERT_IMP(a_oor_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0, "oor read not zero")
	`MTBA_ASSERT_NXT(a_cfg_write, clk, arst_n, cfg_we, vertex_count_q == $past(pwdata[12:0]), "cfg lost")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench of the morph target blend accumulate unit
// depends on mtba_pkg and morph_target_blend_accumulate_unit; predicts read results from
// a behavioral copy of the vertex store, channel weight, thresholds and shape factors
`timescale 1ns / 100ps

module testbench;
	import mtba_pkg::*;

	// ops above read vertex are taken and dropped
	localparam logic [2:0] OP_SPARE = 3'd5;
	localparam int NVERT = 4096;
	localparam int NSHAPE = 8;
	localparam int TIME_LIMIT = 2000000;
	// longest back-end work for one item, used before register writes and at the end
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		logic [2:0]         op;
		logic [11:0]        vi;
		logic [2:0]         slot;
		logic signed [23:0] value;
		logic               last;
		logic [5:0][31:0]   d;      // px py pz nx ny nz, px lowest
	} blend_item_t;

	typedef struct packed {
		logic [5:0][31:0] d;
		logic             in_range;
	} vertex_result_t;

	typedef struct {
		bit             is_cfg;
		logic [31:0]    cfg_val;
		blend_item_t    it;
		bit             typed;
		vertex_result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [231:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [191:0] m_tdata;
	logic m_tuser;

	always #10 clk = ~clk;

	morph_target_blend_accumulate_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// shadow state of the block
	logic signed [31:0] vert_mem [NVERT][6];
	bit                 vert_written [NVERT];
	int                 written_list [$];
	int unsigned        vertex_count_q;
	int                 chan_weight;
	int                 thr_table [NSHAPE];
	int unsigned        shape_count_q;
	int unsigned        shape_factor [NSHAPE];

	vertex_result_t pending_reads [$];
	int  n_errors = 0;
	bit  quiet = 1'b0;     // no idling on either side
	bit  hold_req = 1'b0;  // ask the receiver for one long hold-off

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic int unsigned clamp_ratio(input int w, input int t);
		if (w <= 0) return 0;
		if (w >= t) return ONE_Q16;
		return int'((longint'(w) * 65536) / longint'(t));
	endfunction

	// one factor per shape from the weight and the stored thresholds
	function automatic void recompute_factors();
		int n;
		int w;
		longint span;
		int unsigned f;
		n = shape_count_q;
		w = chan_weight;
		foreach (shape_factor[k]) shape_factor[k] = 0;
		if (n == 0) return;
		if (n == 1) begin
			shape_factor[0] = (thr_table[0] > 1) ? clamp_ratio(w, thr_table[0]) :
				(w > 0 ? ONE_Q16 : 0);
			return;
		end
		if (w <= thr_table[0]) begin
			shape_factor[0] = (thr_table[0] > 1) ? clamp_ratio(w, thr_table[0]) : ONE_Q16;
			return;
		end
		if (w >= thr_table[n-1]) begin
			shape_factor[n-1] = ONE_Q16;
			return;
		end
		for (int i = 1; i < n; i++) begin
			if (w < thr_table[i]) begin
				span = longint'(thr_table[i]) - thr_table[i-1];
				f = ONE_Q16;
				if (span > 1)
					f = int'(((longint'(w) - thr_table[i-1]) * 65536) / span);
				shape_factor[i-1] = ONE_Q16 - f;
				shape_factor[i] = f;
				return;
			end
		end
	endfunction

	function automatic logic signed [31:0] add_scaled(input logic signed [31:0] acc,
			input logic signed [31:0] delta, input int unsigned f);
		longint p;
		p = longint'(delta) * longint'(f);
		return sat32(longint'(acc) + (p >>> 16));
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] unit_comp(input logic signed [31:0] n,
			input logic [63:0] len);
		longint mag;
		longint q;
		mag = (n < 0) ? -longint'(n) : longint'(n);
		q = (mag * 65536) / longint'(len);
		return sat32((n < 0) ? -q : q);
	endfunction

	// apply one accepted item to the shadow state, return 1 with the read result
	function automatic bit blend_step(input blend_item_t it, output vertex_result_t res);
		int unsigned f;
		longint a, b, c;
		logic [63:0] sq, len;
		res = '0;
		case (it.op)
			OP_LOAD: begin
				for (int j = 0; j < 6; j++) vert_mem[it.vi][j] = it.d[j];
				if (!vert_written[it.vi]) written_list.push_back(it.vi);
				vert_written[it.vi] = 1'b1;
			end
			OP_CHAN: begin
				chan_weight = it.value;
				shape_count_q = 0;
				foreach (shape_factor[k]) shape_factor[k] = 0;
			end
			OP_THR: begin
				if (shape_count_q < NSHAPE) begin
					thr_table[shape_count_q] = it.value;
					shape_count_q++;
				end
				if (it.last) recompute_factors();
			end
			OP_DELTA: begin
				if (it.vi < vertex_count_q) begin
					f = shape_factor[it.slot];
					if (f > 1)
						for (int j = 0; j < 6; j++)
							vert_mem[it.vi][j] = add_scaled(vert_mem[it.vi][j], it.d[j], f);
				end
			end
			OP_READ: begin
				if (it.vi < vertex_count_q) begin
					for (int j = 0; j < 6; j++) res.d[j] = vert_mem[it.vi][j];
					a = longint'(vert_mem[it.vi][3]);
					b = longint'(vert_mem[it.vi][4]);
					c = longint'(vert_mem[it.vi][5]);
					sq = 64'(a * a) + 64'(b * b) + 64'(c * c);
					// short normals come back unchanged
					if (sq > 64'd65536) begin
						len = isqrt64(sq);
						for (int j = 3; j < 6; j++) res.d[j] = unit_comp(vert_mem[it.vi][j], len);
					end
					res.in_range = 1'b1;
				end
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic report(input string what, input int idx, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s[%0d]: got %h want %h at %0t", what, idx, got, want, $realtime);
		n_errors++;
	endtask

	// offer one item, keep tvalid high into the next item
	task automatic push_item(input blend_item_t it, input bit typed, input vertex_result_t want);
		vertex_result_t got_pred;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tlast  <= it.last;
		s_tdata  <= {1'b0, it.d, it.value, it.slot, it.vi};
		do @(posedge clk); while (!s_tready);
		if (blend_step(it, got_pred)) pending_reads.push_back(typed ? want : got_pred);
	endtask

	// registers change only when the block has nothing left to do
	task automatic write_vertex_count(input logic [31:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_reads.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_VERTEX_COUNT; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		vertex_count_q = v[12:0];
		@(posedge clk);
	endtask

	function automatic blend_item_t mk(input logic [2:0] op, input int vi, input int slot,
			input int value, input bit last, input logic [5:0][31:0] d);
		blend_item_t it;
		it.op = op; it.vi = vi; it.slot = slot; it.value = value; it.last = last; it.d = d;
		return it;
	endfunction

	// an index that never reaches an unwritten entry inside the vertex range
	function automatic int pick_index();
		int r;
		if (written_list.size() > 0 && $urandom_range(0, 3) != 0)
			return written_list[$urandom_range(0, written_list.size() - 1)];
		r = $urandom_range(0, NVERT - 1);
		if (r < vertex_count_q && !vert_written[r])
			r = written_list[$urandom_range(0, written_list.size() - 1)];
		return r;
	endfunction

	function automatic logic [31:0] rand_word(input bit normal);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 40) - 20;
			default: return normal ? 32'($signed($urandom_range(0, 262144)) - 131072)
				: 32'($signed($urandom_range(0, 2097152)) - 1048576);
		endcase
	endfunction

	function automatic logic [5:0][31:0] rand_vec();
		logic [5:0][31:0] d;
		for (int j = 0; j < 6; j++) d[j] = rand_word(j >= 3);
		return d;
	endfunction

	localparam vertex_result_t NO_VERTEX = '0;

	// directed part: extremes, every op and the named corner cases
	task automatic run_directed();
		stim_row_t rows [$];
		stim_row_t r;
		vertex_result_t w;
		r = '{default: '0};
		// out-of-range read straight after reset returns all zeros
		r.it = mk(OP_READ, 0, 0, 0, 0, '0); r.typed = 1; r.want = NO_VERTEX; rows.push_back(r);
		r = '{default: '0};
		r.is_cfg = 1; r.cfg_val = 32'd4096; rows.push_back(r);
		// short normal left alone
		r = '{default: '0};
		r.it = mk(OP_LOAD, 0, 0, 0, 0, {32'd0, 32'd0, 32'd1, 32'd3, 32'd2, 32'd1});
		rows.push_back(r);
		w = '0; w.d = {32'd0, 32'd0, 32'd1, 32'd3, 32'd2, 32'd1}; w.in_range = 1;
		r = '{default: '0};
		r.it = mk(OP_READ, 0, 0, 0, 0, '0); r.typed = 1; r.want = w; rows.push_back(r);
		// top vertex with extreme positions, unit normal along x
		r = '{default: '0};
		r.it = mk(OP_LOAD, 4095, 0, 0, 0, {32'd0, 32'd0, 32'd65536,
			32'h7fffffff, 32'h80000000, 32'h7fffffff});
		rows.push_back(r);
		w = '0; w.d = {32'd0, 32'd0, 32'd65536, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
		w.in_range = 1;
		r = '{default: '0};
		r.it = mk(OP_READ, 4095, 0, 0, 0, '0); r.typed = 1; r.want = w; rows.push_back(r);
		// largest weight over one threshold: full factor, deltas saturate
		r = '{default: '0}; r.it = mk(OP_CHAN, 0, 0, 24'sh7fffff, 0, '0); rows.push_back(r);
		r.it = mk(OP_THR, 0, 0, 65536, 1, '0); rows.push_back(r);
		r.it = mk(OP_DELTA, 4095, 0, 0, 0, {32'h80000000, 32'h7fffffff, 32'hffffffff,
			32'd5, 32'h80000000, 32'h7fffffff});
		rows.push_back(r);
		// delta in an empty slot is skipped
		r.it = mk(OP_DELTA, 4095, 7, 0, 0, {6{32'h12345678}}); rows.push_back(r);
		r.it = mk(OP_READ, 4095, 0, 0, 0, '0); rows.push_back(r);
		// most negative weight over a tiny threshold: factor 0
		r.it = mk(OP_CHAN, 0, 0, 24'sh800000, 0, '0); rows.push_back(r);
		r.it = mk(OP_THR, 0, 0, 1, 1, '0); rows.push_back(r);
		r.it = mk(OP_DELTA, 0, 0, 0, 0, {6{32'h00010000}}); rows.push_back(r);
		// two in-between shapes, weight halfway
		r.it = mk(OP_CHAN, 0, 0, 98304, 0, '0); rows.push_back(r);
		r.it = mk(OP_THR, 0, 0, 65536, 0, '0); rows.push_back(r);
		r.it = mk(OP_THR, 0, 0, 131072, 1, '0); rows.push_back(r);
		r.it = mk(OP_DELTA, 0, 0, 0, 0, {32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65536});
		rows.push_back(r);
		r.it = mk(OP_DELTA, 0, 1, 0, 0, {32'd0, 32'd65536, 32'd0, 32'hfffe0000, 32'd7, 32'd0});
		rows.push_back(r);
		r.it = mk(OP_READ, 0, 0, 0, 0, '0); rows.push_back(r);
		// undefined ops are dropped
		for (int k = 0; k < 3; k++) begin
			r.it = mk(OP_SPARE + 3'(k), 4095, 7, -1, 1, {6{32'hffffffff}}); rows.push_back(r);
		end
		// nine thresholds: the ninth is dropped, its last mark still counts
		r.it = mk(OP_CHAN, 0, 0, 24'sh7fffff, 0, '0); rows.push_back(r);
		for (int k = 0; k < 9; k++) begin
			r.it = mk(OP_THR, 0, 0, 1000 * k, k == 8, '0); rows.push_back(r);
		end
		r.it = mk(OP_DELTA, 4095, 7, 0, 0, {6{32'h00000100}}); rows.push_back(r);
		r.it = mk(OP_READ, 4095, 0, 0, 0, '0); rows.push_back(r);
		// vertex_count at zero: deltas skipped, reads out of range
		r = '{default: '0}; r.is_cfg = 1; r.cfg_val = 32'd0; rows.push_back(r);
		r = '{default: '0};
		r.it = mk(OP_DELTA, 0, 7, 0, 0, {6{32'h00100000}}); rows.push_back(r);
		r.it = mk(OP_READ, 4095, 0, 0, 0, '0); r.typed = 1; r.want = NO_VERTEX; rows.push_back(r);
		foreach (rows[i]) begin
			if (rows[i].is_cfg) write_vertex_count(rows[i].cfg_val);
			else push_item(rows[i].it, rows[i].typed, rows[i].want);
		end
	endtask

	// one channel: weight, thresholds, then deltas and reads with random content
	task automatic random_channel();
		int n, base, t;
		n = $urandom_range(1, 9);
		base = $signed($urandom_range(0, 400000)) - 200000;
		push_item(mk(OP_CHAN, 0, 0, ($urandom_range(0, 4) == 0) ? $urandom :
			base + $signed($urandom_range(0, 9 * 60000)) - 30000, 0, '0), 0, NO_VERTEX);
		t = base;
		for (int k = 0; k < n; k++) begin
			push_item(mk(OP_THR, 0, 0, ($urandom_range(0, 9) == 0) ? $urandom : t,
				k == n - 1, '0), 0, NO_VERTEX);
			t += ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 100000);
		end
		repeat ($urandom_range(2, 10)) begin
			case ($urandom_range(0, 9))
				0: push_item(mk(OP_LOAD, pick_index(), 0, 0, 0, rand_vec()), 0, NO_VERTEX);
				1, 2, 3: push_item(mk(OP_READ, pick_index(), 0, 0, 0, '0), 0, NO_VERTEX);
				// noise: an undefined op or a read, with random fields
				4: push_item(mk(($urandom_range(0, 1)) ? OP_SPARE + 3'($urandom_range(0, 2)) :
					OP_READ, pick_index(), $urandom, $urandom, $urandom, rand_vec()), 0, NO_VERTEX);
				default: push_item(mk(OP_DELTA, pick_index(), $urandom_range(0, n < 8 ? n : 7),
					0, 0, rand_vec()), 0, NO_VERTEX);
			endcase
		end
	endtask

	// receiver: random stalls, one long hold-off, checks every result item
	initial begin : result_side
		vertex_result_t got, want;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.d = m_tdata;
				got.in_range = m_tuser;
				if (pending_reads.size() == 0) begin
					$display("unexpected result item %h at %0t", m_tdata, $realtime);
					n_errors++;
				end else begin
					want = pending_reads.pop_front();
					for (int j = 0; j < 6; j++)
						if (got.d[j] !== want.d[j]) report("out", j, got.d[j], want.d[j]);
					if (got.in_range !== want.in_range)
						report("in_range", 0, got.in_range, want.in_range);
				end
			end
		end
	end

	// watchdog
	initial begin : watchdog
		int cycles;
		for (cycles = 0; cycles < TIME_LIMIT; cycles++) @(posedge clk);
		$display("testbench: errors");
		$finish;
	end

	initial begin : stimulus
		int sent_mark;
		foreach (shape_factor[k]) shape_factor[k] = 0;
		foreach (vert_written[k]) vert_written[k] = 1'b0;
		vertex_count_q = 0; chan_weight = 0; shape_count_q = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		// random phases over several vertex counts; the last one runs without idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_vertex_count(4096);
				1: write_vertex_count($urandom_range(1, 64));
				2: write_vertex_count($urandom);
				default: write_vertex_count($urandom_range(1, 4096));
			endcase
			repeat (6) push_item(mk(OP_LOAD, $urandom_range(0, vertex_count_q > 0 ?
				vertex_count_q - 1 : 0), 0, 0, 0, rand_vec()), 0, NO_VERTEX);
			if (ph == 1) hold_req = 1'b1;
			if (ph == 3) quiet = 1'b1;
			for (int k = 0; k < 12; k++) random_channel();
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_reads.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
